/* sv/fpv_pkg.sv */
// Package for the framed packet validator: word types, status codes, constants
// and the bitwise CRC-16 byte update. No dependencies.
package fpv_pkg;

  // Width of the per-frame byte counter
  localparam int LENGTH_BITS = 16;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  START_0  = 8'hFF;
  localparam logic [7:0]  START_1  = 8'hFD;
  localparam logic [7:0]  DATA_BIT = 8'h40;
  localparam logic [7:0]  LEN_MASK = 8'h3F;
  localparam logic [7:0]  MAGIC_SET_MASK = 8'hC0;
  localparam logic [7:0]  MAGIC_CLR_MASK = 8'hBF;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_BAD_START = 3'd1;
  localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
  localparam logic [2:0] STATUS_BAD_CRC   = 3'd3;
  localparam logic [2:0] STATUS_SHORT     = 3'd4;

  typedef logic [LENGTH_BITS-1:0] len_t;

  localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  control_byte;
    logic [7:0]  magic_number;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic        data_flag;
    logic [5:0]  payload_length;
    logic [15:0] frame_length;
    logic [15:0] crc_residue;
  } out_word_t;

  // Frame summary captured at the last byte
  typedef struct packed {
    logic        start_bad;
    len_t        len;
    logic [7:0]  control;
    logic [7:0]  dest;
    logic [7:0]  source;
    logic [15:0] crc;
  } frame_sum_t;

  // Shift one byte, MSB first, through the augmented CRC register
  function automatic logic [15:0] crc_byte(input logic [15:0] reg_in, input logic [7:0] b);
    logic [15:0] r;
    logic        top;
    r = reg_in;
    for (int i = 0; i < 8; i++) begin
      top = r[15];
      r   = {r[14:0], b[7-i]};
      if (top) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

/* sv/fpv_report.sv */
// Report logic: turns a captured frame summary into a result word.
// Depends on fpv_pkg (types, status codes, crc_byte).
module fpv_report (
  input  fpv_pkg::frame_sum_t sum,
  output fpv_pkg::out_word_t  word
);

  logic [15:0]                          residue;
  logic                                 flag;
  logic [5:0]                           plen;
  logic [fpv_pkg::LENGTH_BITS+15:0]     len_wide;
  fpv_pkg::len_t                        plen_ext;

  // Flush two zero bytes through the register
  assign residue  = fpv_pkg::crc_byte(fpv_pkg::crc_byte(sum.crc, 8'h00), 8'h00);
  assign flag     = |(sum.control & fpv_pkg::DATA_BIT);
  assign plen     = 6'(sum.control & fpv_pkg::LEN_MASK);
  assign len_wide = {16'h0000, sum.len};
  assign plen_ext = fpv_pkg::len_t'(plen);

  // Pick the status in priority order and assemble the word
  always_comb begin
    if (sum.start_bad) begin
      word.status = fpv_pkg::STATUS_BAD_START;
    end else if (sum.len < fpv_pkg::len_t'(3)) begin
      word.status = fpv_pkg::STATUS_SHORT;
    end else if (flag && (sum.len < fpv_pkg::len_t'(7) ||
                          plen_ext != sum.len - fpv_pkg::len_t'(7))) begin
      word.status = fpv_pkg::STATUS_BAD_LEN;
    end else if (residue != 16'h0000) begin
      word.status = fpv_pkg::STATUS_BAD_CRC;
    end else begin
      word.status = fpv_pkg::STATUS_OK;
    end
    word.control_byte   = sum.control;
    word.magic_number   = flag ? (sum.control & fpv_pkg::MAGIC_SET_MASK)
                               : (sum.control & fpv_pkg::MAGIC_CLR_MASK);
    word.dest_addr      = sum.dest;
    word.src_addr       = sum.source;
    word.data_flag      = flag;
    word.payload_length = plen;
    word.frame_length   = (|len_wide[fpv_pkg::LENGTH_BITS+15:16]) ? 16'hFFFF
                                                                 : len_wide[15:0];
    word.crc_residue    = residue;
  end

endmodule

/* sv/framed_packet_validator.sv */
// Framed packet validator: one byte per cycle unless stalled, one result word per frame.
// A byte is registered in the input stage at acceptance and then updates the frame state;
// a last byte's summary is registered in the summary stage and the result word in the
// output register after it. Throughput is one byte per cycle while no last byte waits on
// a full summary stage, set by the byte-wide CRC update in the frame state loop.
// Synchronous active-high reset empties all stages and clears crc_init to zero.
module framed_packet_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpv_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output fpv_pkg::out_word_t  out_word,
  input  logic                cfg_write_en,
  input  logic [15:0]         cfg_write_data
);

  logic                 crc_init;
  logic [15:0]          crc_init_val;

  // Input stage
  logic                 in_q_valid;
  fpv_pkg::in_word_t    in_q;

  // Frame state
  fpv_pkg::len_t        pos;
  fpv_pkg::len_t        pos_next;
  logic [15:0]          crc_reg;
  logic [15:0]          crc_reg_next;
  logic                 start_bad;
  logic                 start_bad_next;
  logic [7:0]           held_control;
  logic [7:0]           held_control_next;
  logic [7:0]           held_dest;
  logic [7:0]           held_dest_next;
  logic [7:0]           held_source;
  logic [7:0]           held_source_next;

  // Summary and result stages
  logic                 sum_valid;
  fpv_pkg::frame_sum_t  sum;
  fpv_pkg::frame_sum_t  sum_next;
  fpv_pkg::out_word_t   report;

  logic                 out_ready;
  logic                 sum_ready;
  logic                 in_adv;
  logic                 first;
  fpv_pkg::len_t        p;
  fpv_pkg::len_t        len;
  logic [15:0]          crc_base;
  logic [7:0]           b;

  // Stage readiness, walking back from the output
  assign out_ready = !out_valid || !out_stall;
  assign sum_ready = !sum_valid || out_ready;
  assign in_adv    = in_q_valid && (!in_q.last_byte || sum_ready);
  assign in_stall  = in_q_valid && !in_adv;

  // Frame state update for the held word
  always_comb begin
    b     = in_q.data_byte;
    first = (pos == '0);
    if (first && b == fpv_pkg::START_1 && !in_q.last_byte) begin
      p = fpv_pkg::len_t'(1);
    end else begin
      p = pos;
    end
    crc_base          = first ? crc_init_val : crc_reg;
    start_bad_next    = (first ? 1'b0 : start_bad)
                        | (p == fpv_pkg::len_t'(0) && b != fpv_pkg::START_0)
                        | (p == fpv_pkg::len_t'(1) && b != fpv_pkg::START_1);
    held_control_next = (p == fpv_pkg::len_t'(2)) ? b : (first ? 8'h00 : held_control);
    held_dest_next    = (p == fpv_pkg::len_t'(3)) ? b : (first ? 8'h00 : held_dest);
    held_source_next  = (p == fpv_pkg::len_t'(4)) ? b : (first ? 8'h00 : held_source);
    crc_reg_next      = (p >= fpv_pkg::len_t'(2)) ? fpv_pkg::crc_byte(crc_base, b) : crc_base;
    len               = (p == fpv_pkg::LEN_MAX) ? p : p + fpv_pkg::len_t'(1);
    pos_next          = in_q.last_byte ? '0 : len;
    sum_next.start_bad = start_bad_next;
    sum_next.len       = len;
    sum_next.control   = held_control_next;
    sum_next.dest      = held_dest_next;
    sum_next.source    = held_source_next;
    sum_next.crc       = crc_reg_next;
  end

  fpv_report u_report (
    .sum  (sum),
    .word (report)
  );

  // Hold config, advance stages, update frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_init     <= 1'b0;
      crc_init_val <= 16'h0000;
      in_q_valid   <= 1'b0;
      sum_valid    <= 1'b0;
      out_valid    <= 1'b0;
      pos          <= '0;
      start_bad    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        crc_init     <= 1'b1;
        crc_init_val <= cfg_write_data;
      end
      if (!in_stall) begin
        in_q_valid <= in_valid;
        in_q       <= in_word;
      end
      if (in_adv) begin
        pos          <= pos_next;
        crc_reg      <= crc_reg_next;
        start_bad    <= start_bad_next;
        held_control <= held_control_next;
        held_dest    <= held_dest_next;
        held_source  <= held_source_next;
      end
      if (sum_ready) begin
        sum_valid <= in_adv && in_q.last_byte;
        if (in_adv && in_q.last_byte) begin
          sum <= sum_next;
        end
      end
      if (out_ready) begin
        out_valid <= sum_valid;
        if (sum_valid) begin
          out_word <= report;
        end
      end
    end
  end

  // Stall only while a last word waits for the summary stage
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && in_q.last_byte && sum_valid))
    else $error("input stalled without a blocked last word");

  // A waiting summary is not overwritten
  assert property (@(posedge clk) disable iff (rst)
    (sum_valid && !out_ready) |=> (sum_valid && $stable(sum)))
    else $error("summary lost while output blocked");

  // Frame position returns to zero after a last word
  assert property (@(posedge clk) disable iff (rst)
    (in_adv && in_q.last_byte) |=> (pos == '0))
    else $error("frame position not cleared after last word");

  // An ok result always carries a zero residue
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status == fpv_pkg::STATUS_OK) |-> (out_word.crc_residue == 16'h0000))
    else $error("ok status with nonzero residue");

  // crc_init flag is only a record that a write happened
  assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> crc_init)
    else $error("configuration write not recorded");

endmodule
